// File: hdl/abelian_square_suffix_detector_defines.svh
// ----------------------------------------------------------------------------
// abelian square suffix detector assertion macros
// shared assertion forms for the detector rtl
// ----------------------------------------------------------------------------
`ifndef ABELIAN_SQUARE_SUFFIX_DETECTOR_DEFINES_SVH
`define ABELIAN_SQUARE_SUFFIX_DETECTOR_DEFINES_SVH

// implication checked at every clock edge outside reset
`define ASD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked outside reset
`define ASD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/asd_pkg.sv
// ----------------------------------------------------------------------------
// asd_pkg
// types and constants of the abelian square suffix detector
// ----------------------------------------------------------------------------
`default_nettype none

package asd_pkg;

  // fixed field widths
  localparam int CFG_W       = 12;
  localparam int WL_W        = 13;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 16;

  // defaults
  localparam int DEF_MAX_LEN = 4096;
  localparam logic [CFG_W-1:0] MIN_BLOCK_RST = 12'd21;

  // request modes
  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  // counted letters
  localparam logic [1:0] LETTER_A = 2'd0;
  localparam logic [1:0] LETTER_B = 2'd1;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_APP_RD,
    S_APP_WR,
    S_LEN_RD,
    S_LEN_LD,
    S_SCAN,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

// File: hdl/abelian_square_suffix_detector.sv
// ----------------------------------------------------------------------------
// abelian_square_suffix_detector
// one request at a time; the scan ends early on a match, and the shared compare
// checks one block size a cycle; a finished result may wait while the next is taken
// reset (rst, synchronous) clears the length, the control and min_block to 21;
// the count memories are not cleared, entry zero reads as zero
// ----------------------------------------------------------------------------
`default_nettype none

module abelian_square_suffix_detector
  import asd_pkg::*;
#(
  parameter int MAX_LEN = DEF_MAX_LEN
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // config
  input  wire logic                  cfg_we,
  input  wire logic [CFG_W-1:0]      cfg_wdata,      // min_block
  // input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // mode[1:0], letter[3:2], zero pad
  // result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata    // has_square[0], word_length[13:1],
                                                     // full_res[14], zero pad
);

  localparam int LW    = $clog2(MAX_LEN + 1);
  localparam int DEPTH = MAX_LEN + 1;
  localparam int KW    = ((LW > CFG_W) ? LW : CFG_W) + 1;

  // prefix count memories
  logic [LW-1:0] pca [DEPTH];
  logic [LW-1:0] pcb [DEPTH];

  state_t state, state_next;

  logic [CFG_W-1:0] min_block;
  logic [LW-1:0]    len;
  logic [LW-1:0]    half;
  logic [KW-1:0]    k;
  logic             cmp_vld;
  logic [1:0]       letter_q;
  logic             full_q;
  logic             hit_q;
  logic [LW-1:0]    pn_a, pn_b;

  logic [LW-1:0]    rd_addr0, rd_addr1;
  logic [LW-1:0]    rd_a0, rd_b0, rd_a1, rd_b1;
  logic             z0, z1;
  logic [LW-1:0]    ea0, eb0, ea1, eb1;

  logic             wr_en;
  logic [LW-1:0]    wr_addr, wr_a, wr_b;

  logic             out_hs;
  logic [WL_W-1:0]  out_wl;
  logic             out_full;

  logic             in_acc, out_load, scan_issue, match;
  logic [KW-1:0]    kmin;
  logic [LW-1:0]    mid_addr, lo_addr;
  logic [LW:0]      sum_a, sum_b;
  logic [1:0]       in_mode, in_letter;

  assign in_mode   = s_axis_tdata[1:0];
  assign in_letter = s_axis_tdata[3:2];
  assign in_acc    = s_axis_tvalid && s_axis_tready;

  // smallest block size, zero treated as one
  assign kmin = (min_block == '0) ? KW'(1) : KW'(min_block);

  // scan addresses and compare
  assign mid_addr   = len - k[LW-1:0];
  assign lo_addr    = len - {k[LW-2:0], 1'b0};
  assign scan_issue = (k <= KW'(half));
  assign ea0 = z0 ? '0 : rd_a0;
  assign eb0 = z0 ? '0 : rd_b0;
  assign ea1 = z1 ? '0 : rd_a1;
  assign eb1 = z1 ? '0 : rd_b1;
  assign sum_a = {1'b0, pn_a} + {1'b0, ea1};
  assign sum_b = {1'b0, pn_b} + {1'b0, eb1};
  assign match = (sum_a == {ea0, 1'b0}) && (sum_b == {eb0, 1'b0});

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_block <= MIN_BLOCK_RST;
    end else if (cfg_we) begin
      min_block <= cfg_wdata;
    end
  end

  // memory write and two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pca[wr_addr] <= wr_a;
      pcb[wr_addr] <= wr_b;
    end
    rd_a0 <= pca[rd_addr0];
    rd_b0 <= pcb[rd_addr0];
    rd_a1 <= pca[rd_addr1];
    rd_b1 <= pcb[rd_addr1];
    z0    <= (rd_addr0 == '0);
    z1    <= (rd_addr1 == '0);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and control
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = len + LW'(1);
    wr_a          = ea0 + ((letter_q == LETTER_A) ? LW'(1) : LW'(0));
    wr_b          = eb0 + ((letter_q == LETTER_B) ? LW'(1) : LW'(0));
    rd_addr0      = len;
    rd_addr1      = lo_addr;
    case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if ((in_mode == MODE_APPEND) && (len != LW'(MAX_LEN))) begin
            state_next = S_APP_RD;
          end else begin
            state_next = S_LEN_RD;
          end
        end
      end
      S_APP_RD: begin
        state_next = S_APP_WR;
      end
      S_APP_WR: begin
        wr_en      = 1'b1;
        state_next = S_SCAN;
      end
      S_LEN_RD: begin
        state_next = S_LEN_LD;
      end
      S_LEN_LD: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        rd_addr0 = mid_addr;
        if ((cmp_vld && match) || !scan_issue) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // word length and request control
  always_ff @(posedge clk) begin
    if (rst) begin
      len     <= '0;
      cmp_vld <= 1'b0;
      full_q  <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            letter_q <= in_letter;
            full_q   <= (in_mode == MODE_APPEND) && (len == LW'(MAX_LEN));
            case (in_mode)
              MODE_REMOVE: begin
                if (len != '0) begin
                  len <= len - LW'(1);
                end
              end
              MODE_CLEAR: begin
                len <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_APP_WR: begin
          len     <= len + LW'(1);
          half    <= (len + LW'(1)) >> 1;
          pn_a    <= wr_a;
          pn_b    <= wr_b;
          k       <= kmin;
          cmp_vld <= 1'b0;
        end
        S_LEN_RD: begin
          half    <= len >> 1;
          k       <= kmin;
          cmp_vld <= 1'b0;
        end
        S_LEN_LD: begin
          pn_a <= ea0;
          pn_b <= eb0;
        end
        S_SCAN: begin
          if (cmp_vld && match) begin
            hit_q <= 1'b1;
          end else if (!scan_issue) begin
            hit_q <= 1'b0;
          end else begin
            k       <= k + KW'(1);
            cmp_vld <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hs   <= hit_q;
      out_wl   <= WL_W'(len);
      out_full <= full_q;
    end
  end

  assign m_axis_tdata = {1'b0, out_full, out_wl, out_hs};

  // checks
`include "abelian_square_suffix_detector_defines.svh"

  `ASD_ASSERT_IMPL(a_len_bound, 1'b1, len <= LW'(MAX_LEN), "word length above maximum")
  `ASD_ASSERT_IMPL(a_scan_order, (state == S_SCAN) && scan_issue, lo_addr <= mid_addr, "scan address order broken")
  `ASD_ASSERT_NEXT(a_out_valid, out_load, m_axis_tvalid && (state == S_IDLE), "result not presented")

endmodule

`default_nettype wire

// File: tb/asd_checker.sv
// ----------------------------------------------------------------------------
// asd_checker
// watches the config port and both streams of the abelian square suffix
// detector, keeps its own copy of the prefix counts and compares every result
// ----------------------------------------------------------------------------
module asd_checker
  import asd_pkg::*;
#(
  parameter int MAX_LEN = DEF_MAX_LEN
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_W-1:0]      cfg_wdata,
  input  wire logic                  s_axis_tvalid,
  input  wire logic                  s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // mode[1:0], letter[3:2], zero pad
  input  wire logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,   // has_square[0], word_length[13:1],
                                                     // full_res[14], zero pad
  output int                         fail_count,
  output int                         pending_count,
  output int                         request_count,
  output int                         square_count,
  output int                         reject_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // one result as it sits in the low bits of m_axis_tdata
  typedef struct packed {
    logic            full_res;
    logic [WL_W-1:0] word_length;
    logic            has_square;
  } verdict_t;

  // shadow of the word: running counts of a and b, entry i covers i letters
  logic [WL_W-1:0]  count_a [0:MAX_LEN];
  logic [WL_W-1:0]  count_b [0:MAX_LEN];
  int unsigned      word_len;
  logic [CFG_W-1:0] min_blk;

  verdict_t         verdict_q[$];
  verdict_t         want;
  verdict_t         got;
  int               mismatches = 0;
  int               requests = 0;
  int               squares = 0;
  int               rejects = 0;

  // apply one request to the shadow word and work out its result
  function automatic verdict_t apply_request(input mode_t m, input logic [1:0] l);
    verdict_t    v;
    int unsigned k;
    int unsigned mid;
    int unsigned lo;
    v = '0;
    case (m)
      MODE_APPEND: begin
        if (word_len >= MAX_LEN) begin
          v.full_res = 1'b1;
        end else begin
          count_a[word_len + 1] = count_a[word_len] + WL_W'(l == LETTER_A);
          count_b[word_len + 1] = count_b[word_len] + WL_W'(l == LETTER_B);
          word_len++;
        end
      end
      MODE_REMOVE: begin
        if (word_len > 0) word_len--;
      end
      MODE_CLEAR: begin
        word_len = 0;
      end
      default: ;
    endcase
    // try each block size from min_block (zero counts as one) up to half the word, up to the first match
    k = (min_blk == '0) ? 1 : min_blk;
    while (!v.has_square && k <= word_len / 2) begin
      mid = word_len - k;
      lo  = word_len - 2 * k;
      if (count_a[word_len] - count_a[mid] == count_a[mid] - count_a[lo] &&
          count_b[word_len] - count_b[mid] == count_b[mid] - count_b[lo])
        v.has_square = 1'b1;
      k++;
    end
    v.word_length = WL_W'(word_len);
    return v;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      word_len   = 0;
      min_blk    = MIN_BLOCK_RST;
      count_a[0] = '0;
      count_b[0] = '0;
      verdict_q.delete();
    end else begin
      if (cfg_we) min_blk = cfg_wdata;
      // results first: a result at this edge always belongs to an older request
      if (m_axis_tvalid && m_axis_tready) begin
        got = verdict_t'(m_axis_tdata[WL_W+1:0]);
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no request pending: square=%0d length=%0d full=%0d",
                     $realtime, got.has_square, got.word_length, got.full_res);
        end else begin
          want = verdict_q.pop_front();
          if (got.has_square !== want.has_square || got.word_length !== want.word_length ||
              got.full_res !== want.full_res) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch, expected square=%0d length=%0d full=%0d, got %0d %0d %0d",
                       $realtime, want.has_square, want.word_length, want.full_res,
                       got.has_square, got.word_length, got.full_res);
          end
        end
      end
      // new request: predict and queue
      if (s_axis_tvalid && s_axis_tready) begin
        want = apply_request(mode_t'(s_axis_tdata[1:0]), s_axis_tdata[3:2]);
        verdict_q.insert(verdict_q.size(), want);
        requests++;
        if (want.has_square) squares++;
        if (want.full_res) rejects++;
      end
    end
    fail_count    <= mismatches;
    pending_count <= verdict_q.size();
    request_count <= requests;
    square_count  <= squares;
    reject_count  <= rejects;
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// drives the abelian square suffix detector with directed corner cases, a
// square built at the reset min_block and random request streams under several
// idling mixes; the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb
  import asd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = DEF_MAX_LEN / 2 + 16;
  localparam int HALF_LEN       = DEF_MAX_LEN / 2;
  localparam int FILL_HALF      = 24;

  // uncounted letter codes
  localparam logic [1:0] LETTER_C = 2'd2;
  localparam logic [1:0] LETTER_X = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // mode[1:0], letter[3:2], zero pad
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // has_square[0], word_length[13:1],
                                              // full_res[14], zero pad

  int fail_count;
  int pending_count;
  int request_count;
  int square_count;
  int reject_count;

  int   send_idle_pct = 0;
  int   rx_stall_pct = 0;
  bit   hold_go = 1'b0;
  int   stim_len = 0;
  int   sent = 0;
  int   idle_cycles = 0;
  logic [1:0] half_word [0:HALF_LEN-1];

  always #2 clk = ~clk;

  abelian_square_suffix_detector u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  asd_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .request_count (request_count),
    .square_count  (square_count),
    .reject_count  (reject_count)
  );

  // one request, with random idle cycles ahead of it
  task automatic send_req(input mode_t m, input logic [1:0] l);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, l, m};
    do @(posedge clk); while (!s_axis_tready);
    sent++;
    case (m)
      MODE_APPEND: begin
        if (stim_len < DEF_MAX_LEN) stim_len++;
      end
      MODE_REMOVE: begin
        if (stim_len > 0) stim_len--;
      end
      MODE_CLEAR: begin
        stim_len = 0;
      end
      default: ;
    endcase
  endtask

  // stop offering and wait until every result is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // min_block write, only with the block idle
  task automatic set_min_block(input logic [CFG_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // random requests: mostly square-building bursts and appends on short words
  task automatic run_phase(input int idle, input int stall, input logic [CFG_W-1:0] mb,
                           input int n);
    int target;
    int r;
    int k;
    int j;
    int rot;
    set_min_block(mb);
    send_idle_pct = idle;
    rx_stall_pct  = stall;
    target = sent + n;
    while (sent < target) begin
      r = $urandom_range(99);
      if (stim_len > 160) begin
        send_req(MODE_CLEAR, 2'($urandom_range(3)));
      end else if (r < 40) begin
        // k random letters, then a rotation of them: an abelian square of size k
        k = $urandom_range(mb + 4, (mb == '0) ? 1 : mb);
        for (j = 0; j < k; j++) begin
          half_word[j] = 2'($urandom_range(2));
          send_req(MODE_APPEND, half_word[j]);
        end
        rot = $urandom_range(k - 1);
        for (j = 0; j < k; j++) send_req(MODE_APPEND, half_word[(j + rot) % k]);
      end else if (r < 70) begin
        send_req(MODE_APPEND, 2'($urandom_range(3)));
      end else if (r < 85) begin
        send_req(MODE_REMOVE, 2'($urandom_range(3)));
      end else if (r < 90) begin
        send_req(MODE_CLEAR, 2'($urandom_range(3)));
      end else if (r < 96) begin
        send_req(MODE_NOP, 2'($urandom_range(3)));
      end else begin
        repeat ($urandom_range(4, 1)) send_req(MODE_REMOVE, 2'($urandom_range(3)));
      end
    end
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin : rx_side
    int n;
    forever begin
      @(posedge clk);
      if (rst) begin
        m_axis_tready <= 1'b0;
      end else if (hold_go) begin
        hold_go = 1'b0;
        m_axis_tready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles without a handshake", idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty word at the reset min_block: removal ignored, idle mode, clear
    send_req(MODE_REMOVE, LETTER_A);
    send_req(MODE_NOP, LETTER_X);
    send_req(MODE_CLEAR, LETTER_B);

    // square of half-size just above the reset min_block, then one more letter
    for (i = 0; i < FILL_HALF; i++) begin
      half_word[i] = 2'($urandom_range(3));
      send_req(MODE_APPEND, half_word[i]);
    end
    for (i = FILL_HALF - 1; i >= 0; i--) send_req(MODE_APPEND, half_word[i]);
    send_req(MODE_APPEND, LETTER_B);
    send_req(MODE_NOP, LETTER_A);

    // min_block above half the word
    set_min_block(12'hFFF);
    send_req(MODE_NOP, LETTER_C);

    // large min_block on a short word
    set_min_block(12'd2047);
    send_req(MODE_REMOVE, LETTER_B);
    send_req(MODE_APPEND, LETTER_A);
    send_req(MODE_APPEND, LETTER_C);
    send_req(MODE_CLEAR, LETTER_X);

    // smallest blocks: aa, uncounted letters, abba
    set_min_block(12'd1);
    send_req(MODE_APPEND, LETTER_A);
    send_req(MODE_APPEND, LETTER_A);
    send_req(MODE_APPEND, LETTER_B);
    send_req(MODE_APPEND, LETTER_C);
    send_req(MODE_APPEND, LETTER_X);
    send_req(MODE_NOP, LETTER_A);
    send_req(MODE_REMOVE, LETTER_B);
    send_req(MODE_APPEND, LETTER_B);
    send_req(MODE_CLEAR, LETTER_C);
    send_req(MODE_APPEND, LETTER_A);
    send_req(MODE_APPEND, LETTER_B);
    send_req(MODE_APPEND, LETTER_B);
    send_req(MODE_APPEND, LETTER_A);
    send_req(MODE_REMOVE, LETTER_X);
    send_req(MODE_APPEND, LETTER_C);
    send_req(MODE_APPEND, LETTER_C);

    // zero min_block behaves as one
    set_min_block(12'd0);
    send_req(MODE_APPEND, LETTER_B);
    send_req(MODE_APPEND, LETTER_B);
    send_req(MODE_REMOVE, LETTER_A);

    // random traffic, no idling
    run_phase(0, 0, 12'd2, 45);

    // long receiver hold-off while requests keep coming, then wait for all results
    hold_go = 1'b1;
    for (i = 0; i < 12; i++) send_req(MODE_APPEND, 2'($urandom_range(2)));
    drain();

    // random traffic under the idling mixes
    run_phase(64, 0, 12'($urandom_range(4, 1)), 45);
    run_phase(0, 64, 12'd3, 45);
    run_phase(34, 34, 12'd1, 45);

    rx_stall_pct  = 0;
    send_idle_pct = 0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests: empty word, squares near min_block, all modes and codes,",
             request_count);
    $display("min_block from 0 to 4095; %0d results with a square suffix, %0d rejected appends",
             square_count, reject_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
